// ===== hw/rtl/phase_bit_record_parser_unit_assert.svh =====
// Assertion macros for the record parser.
// Included by the controller and the datapath; needs nothing else.
`ifndef PHASE_BIT_RECORD_PARSER_UNIT_ASSERT_SVH
`define PHASE_BIT_RECORD_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication under a synchronous active-low reset.
`define PBRP_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under a synchronous active-low reset.
`define PBRP_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pbrp_pkg.sv =====
// Shared constants and controller/datapath interface types for the record parser.
// No dependencies.
package pbrp_pkg;

  localparam int MAX_RECORD_BYTES = 32;
  localparam int ROWS             = MAX_RECORD_BYTES / 2;
  localparam int ROW_W            = $clog2(ROWS);
  localparam int CNT_W            = 6;
  localparam int WORD_CAP         = (ROWS > 16) ? 16 : ROWS;
  localparam int IDX_W            = 4;

  localparam int BYTE_W  = 8;
  localparam int DATA_W  = 7;
  localparam int PHASE_BIT = 7;
  localparam int VALUE_W = 16;

  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WORDS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'd1;
  localparam logic [CFG_W-1:0]     WORDS_RESET = 5'd6;

  typedef struct packed {
    logic take;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic rec_done;
    logic last;
  } sts_t;

endpackage

// ===== hw/rtl/pbrp_datapath.sv =====
// Datapath: config registers, byte counter, two-bank record store, word decode.
// Depends on pbrp_pkg and phase_bit_record_parser_unit_assert.svh.
`include "phase_bit_record_parser_unit_assert.svh"
module pbrp_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pbrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbrp_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [pbrp_pkg::BYTE_W-1:0]    in_rx_byte,
  input  pbrp_pkg::cmd_t                 cmd,
  output pbrp_pkg::sts_t                 sts,
  output logic [pbrp_pkg::VALUE_W-1:0]   out_word_value,
  output logic [pbrp_pkg::IDX_W-1:0]     out_word_index,
  output logic                           out_last_word
);

  logic [pbrp_pkg::CFG_W-1:0]  words_r;
  logic                        en_r;
  logic [pbrp_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                        in_rec_r, in_rec_nxt;
  logic [pbrp_pkg::IDX_W-1:0]  k_r, k_nxt;
  logic [pbrp_pkg::IDX_W-1:0]  last_r, last_nxt;
  logic [pbrp_pkg::DATA_W-1:0] even_mem [pbrp_pkg::ROWS];
  logic [pbrp_pkg::DATA_W-1:0] odd_mem  [pbrp_pkg::ROWS];
  logic [pbrp_pkg::DATA_W-1:0] lo_r, hi_r;

  logic                          phase;
  logic                          live;
  logic                          wr_en;
  logic [pbrp_pkg::ROW_W:0]      wr_addr;
  logic [pbrp_pkg::IDX_W-1:0]    eff_last;
  logic [pbrp_pkg::CNT_W-1:0]    nbytes;
  logic [pbrp_pkg::CNT_W-1:0]    count_inc;
  logic [pbrp_pkg::ROW_W-1:0]    rd_addr;
  logic [pbrp_pkg::IDX_W-1:0]    k_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= pbrp_pkg::WORDS_RESET;
      en_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        pbrp_pkg::REG_WORDS:  words_r <= cfg_wdata;
        pbrp_pkg::REG_ENABLE: en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (words_r == '0) begin
      eff_last = '0;
    end else if (words_r > pbrp_pkg::CFG_W'(pbrp_pkg::WORD_CAP)) begin
      eff_last = pbrp_pkg::IDX_W'(pbrp_pkg::WORD_CAP - 1);
    end else begin
      eff_last = pbrp_pkg::IDX_W'(words_r - 5'd1);
    end
  end

  assign nbytes    = (pbrp_pkg::CNT_W'(eff_last) + 6'd1) << 1;
  assign count_inc = count_r + 6'd1;
  assign phase     = in_rx_byte[pbrp_pkg::PHASE_BIT];
  assign live      = cmd.take && en_r;
  assign wr_en     = live && (phase || in_rec_r);
  assign wr_addr   = phase ? '0 : count_r[pbrp_pkg::ROW_W:0];

  assign sts.rec_done = live && !phase && in_rec_r && (count_inc >= nbytes);
  assign sts.last     = (k_r == last_r);

  always_comb begin
    count_nxt  = count_r;
    in_rec_nxt = in_rec_r;
    last_nxt   = last_r;
    if (live && phase) begin
      count_nxt  = 6'd1;
      in_rec_nxt = 1'b1;
    end else if (sts.rec_done) begin
      count_nxt  = '0;
      in_rec_nxt = 1'b0;
      last_nxt   = eff_last;
    end else if (live && in_rec_r) begin
      count_nxt = count_inc;
    end
  end

  assign k_inc = k_r + 4'd1;

  always_comb begin
    k_nxt = k_r;
    if (sts.rec_done) begin
      k_nxt = '0;
    end else if (cmd.advance) begin
      k_nxt = sts.last ? '0 : k_inc;
    end
  end

  assign rd_addr = cmd.advance ? k_inc[pbrp_pkg::ROW_W-1:0] : k_r[pbrp_pkg::ROW_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      in_rec_r <= 1'b0;
      k_r      <= '0;
      last_r   <= '0;
    end else begin
      count_r  <= count_nxt;
      in_rec_r <= in_rec_nxt;
      k_r      <= k_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_addr[0]) begin
      even_mem[wr_addr[pbrp_pkg::ROW_W:1]] <= in_rx_byte[pbrp_pkg::DATA_W-1:0];
    end
    if (wr_en && wr_addr[0]) begin
      odd_mem[wr_addr[pbrp_pkg::ROW_W:1]] <= in_rx_byte[pbrp_pkg::DATA_W-1:0];
    end
    lo_r <= even_mem[rd_addr];
    hi_r <= odd_mem[rd_addr];
  end

  assign out_word_value = {hi_r, 9'b0} + {7'b0, lo_r, 2'b0};
  assign out_word_index = k_r;
  assign out_last_word  = sts.last;

  `PBRP_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1,
                   count_r < pbrp_pkg::CNT_W'(pbrp_pkg::MAX_RECORD_BYTES),
                   "byte count left the store range")
  `PBRP_ASSERT_NXT(a_done_clears, clk, rst_n, sts.rec_done,
                   count_r == '0 && !in_rec_r && k_r == '0,
                   "record end did not clear collection state")

endmodule

// ===== hw/rtl/pbrp_ctrl.sv =====
// Controller: collect / read / emit sequencing and channel handshakes.
// Depends on pbrp_pkg and phase_bit_record_parser_unit_assert.svh.
`include "phase_bit_record_parser_unit_assert.svh"
module pbrp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pbrp_pkg::sts_t sts,
  output pbrp_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_READ    = 2'd1;
  localparam logic [1:0] ST_EMIT    = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready    = (state_r == ST_COLLECT);
  assign out_valid   = (state_r == ST_EMIT);
  assign cmd.take    = in_valid && in_ready;
  assign cmd.advance = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: if (sts.rec_done) state_nxt = ST_READ;
      ST_READ:    state_nxt = ST_EMIT;
      ST_EMIT:    if (cmd.advance && sts.last) state_nxt = ST_COLLECT;
      default:    state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PBRP_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready,
                   "input taken during word emission")
  `PBRP_ASSERT_NXT(a_done_to_emit, clk, rst_n, sts.rec_done,
                   state_r == ST_READ ##1 out_valid,
                   "record end not followed by emission")

endmodule

// ===== hw/rtl/phase_bit_record_parser_unit.sv =====
// Record parser top: one byte per cycle while collecting; on the record's last
// byte, a read state loads the first word before emission, then one word per cycle as taken.
// A record of N words takes 2N input bytes; input waits during emission.
// rst_n is synchronous, active low: 6 words per record, parsing on, waiting for a phase byte.
// Record store contents are not reset.
module phase_bit_record_parser_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pbrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbrp_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pbrp_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pbrp_pkg::VALUE_W-1:0]   out_word_value,
  output logic [pbrp_pkg::IDX_W-1:0]     out_word_index,
  output logic                           out_last_word
);

  pbrp_pkg::cmd_t cmd;
  pbrp_pkg::sts_t sts;

  pbrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbrp_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_rx_byte     (in_rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_word_value (out_word_value),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

endmodule
